>>> rtl/rgb565_pair_to_yuv422_assert.svh
// Assertion macros for the RGB565 pair to YUV422 converter.
`ifndef RGB565_PAIR_TO_YUV422_ASSERT_SVH
`define RGB565_PAIR_TO_YUV422_ASSERT_SVH

`ifndef SYNTHESIS
// Checked out of reset only.
`define R2Y_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("r2y assertion failed");
// Checked at every edge, reset included.
`define R2Y_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("r2y assertion failed");
`else
`define R2Y_ASSERT(lbl, prop)
`define R2Y_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/r2y_pkg.sv
// Shared types and constants for the RGB565 pair to YUV422 converter.
package r2y_pkg;

  localparam int unsigned PixW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ProdW = 15;  // widest product 129 * 252 fits 15 bits
  localparam int unsigned SumW  = 17;

  typedef logic [PixW-1:0]  pixel_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [ProdW-1:0] prod_w_t;

  // BT.601 studio-range coefficients (magnitudes; signs applied in the sums)
  localparam byte_t C_Y_R = 8'd66;
  localparam byte_t C_Y_G = 8'd129;
  localparam byte_t C_Y_B = 8'd25;
  localparam byte_t C_U_R = 8'd38;
  localparam byte_t C_U_G = 8'd74;
  localparam byte_t C_U_B = 8'd112;
  localparam byte_t C_V_R = 8'd112;
  localparam byte_t C_V_G = 8'd94;
  localparam byte_t C_V_B = 8'd18;
  localparam byte_t C_ROUND = 8'd128;
  localparam byte_t C_Y_OFS = 8'd16;
  localparam byte_t C_C_OFS = 8'd128;

  // Bounds of the converted values over every input pattern
  localparam byte_t Y_MIN = 8'd16;
  localparam byte_t Y_MAX = 8'd231;
  localparam byte_t C_MIN = 8'd18;
  localparam byte_t C_MAX = 8'd237;

  typedef struct packed {
    prod_w_t y_r, y_g, y_b;
    prod_w_t u_r, u_g, u_b;
    prod_w_t v_r, v_g, v_b;
  } prod_t;

  typedef struct packed {
    byte_t y, u, v;
  } yuv_t;

endpackage

>>> rtl/r2y_pix_if.sv
// Input channel: one beat carries a pair of RGB565 pixels.
interface r2y_pix_if
  import r2y_pkg::*;
();
  logic   valid;
  logic   ready;
  pixel_t first_pixel;
  pixel_t second_pixel;

  modport source (output valid, first_pixel, second_pixel, input ready);
  modport sink   (input valid, first_pixel, second_pixel, output ready);
endinterface

>>> rtl/r2y_yuv_if.sv
// Output channel: one beat carries a packed Y0 U Y1 V group.
interface r2y_yuv_if
  import r2y_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t luma_first;
  byte_t chroma_blue;
  byte_t luma_second;
  byte_t chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

>>> rtl/rgb565_pair_to_yuv422.sv
// Top level: three-stage RGB565 pair to YUV422 converter.
//
//  channel | dir | payload                                         | handshake
//  pix_i   | in  | first_pixel, second_pixel (RGB565 each)         | valid/ready
//  yuv_o   | out | luma_first, chroma_blue, luma_second, chroma_red | valid/ready
//
// One pixel pair per cycle while the output is not stalled; each beat is registered in every stage.
// Stages: constant products, sums with rounding and offsets, chroma average.
// Each stage holds its beat while the next one is full and stalled; bubbles
// close up, so input is taken while a finished beat waits at the output.
// Reset clears the stage valid bits only.
`include "rgb565_pair_to_yuv422_assert.svh"

module rgb565_pair_to_yuv422
  import r2y_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  r2y_pix_if.sink   pix_i,
  r2y_yuv_if.source yuv_o
);

  function automatic prod_t products(pixel_t px);
    byte_t r, g, b;
    prod_t p;
    r = {px[15:11], 3'b000};
    g = {px[10:5], 2'b00};
    b = {px[4:0], 3'b000};
    p.y_r = ProdW'(r) * ProdW'(C_Y_R);
    p.y_g = ProdW'(g) * ProdW'(C_Y_G);
    p.y_b = ProdW'(b) * ProdW'(C_Y_B);
    p.u_r = ProdW'(r) * ProdW'(C_U_R);
    p.u_g = ProdW'(g) * ProdW'(C_U_G);
    p.u_b = ProdW'(b) * ProdW'(C_U_B);
    p.v_r = ProdW'(r) * ProdW'(C_V_R);
    p.v_g = ProdW'(g) * ProdW'(C_V_G);
    p.v_b = ProdW'(b) * ProdW'(C_V_B);
    return p;
  endfunction

  // Sums in 17-bit two's complement; bits 15..8 are the floored quotient by 256,
  // and every true value fits a byte after the offset, so the adds just wrap.
  function automatic yuv_t finish(prod_t p);
    logic [SumW-1:0] ys, us, vs;
    yuv_t o;
    ys = SumW'(p.y_r) + SumW'(p.y_g) + SumW'(p.y_b) + SumW'(C_ROUND);
    us = SumW'(p.u_b) - SumW'(p.u_r) - SumW'(p.u_g) + SumW'(C_ROUND);
    vs = SumW'(p.v_r) - SumW'(p.v_g) - SumW'(p.v_b) + SumW'(C_ROUND);
    o.y = ys[15:8] + C_Y_OFS;
    o.u = us[15:8] + C_C_OFS;
    o.v = vs[15:8] + C_C_OFS;
    return o;
  endfunction

  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  logic  s1_en, s2_en, s3_en;
  prod_t s1_p0_q, s1_p1_q;
  yuv_t  s2_c0_q, s2_c1_q;
  byte_t s3_y0_q, s3_u_q, s3_y1_q, s3_v_q;
  logic [ByteW:0] u_sum, v_sum;

  assign s3_en = !s3_valid_q || yuv_o.ready;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;
  assign pix_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= pix_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
    end
  end

  assign u_sum = {1'b0, s2_c0_q.u} + {1'b0, s2_c1_q.u};
  assign v_sum = {1'b0, s2_c0_q.v} + {1'b0, s2_c1_q.v};

  always_ff @(posedge clk_i) begin
    if (s1_en && pix_i.valid) begin
      s1_p0_q <= products(pix_i.first_pixel);
      s1_p1_q <= products(pix_i.second_pixel);
    end
    if (s2_en && s1_valid_q) begin
      s2_c0_q <= finish(s1_p0_q);
      s2_c1_q <= finish(s1_p1_q);
    end
    if (s3_en && s2_valid_q) begin
      s3_y0_q <= s2_c0_q.y;
      s3_y1_q <= s2_c1_q.y;
      s3_u_q  <= u_sum[ByteW:1];
      s3_v_q  <= v_sum[ByteW:1];
    end
  end

  assign yuv_o.valid       = s3_valid_q;
  assign yuv_o.luma_first  = s3_y0_q;
  assign yuv_o.chroma_blue = s3_u_q;
  assign yuv_o.luma_second = s3_y1_q;
  assign yuv_o.chroma_red  = s3_v_q;

  // Input stalls only when every stage holds a beat.
  `R2Y_ASSERT(a_stall_full, !pix_i.ready |-> (s1_valid_q && s2_valid_q && s3_valid_q))
  // A middle beat blocked by the output stays put.
  `R2Y_ASSERT(a_s2_hold, (s2_valid_q && !s3_en) |=> (s2_valid_q && $stable(s2_c0_q)))
  `R2Y_ASSERT(a_luma_range, yuv_o.valid |-> (yuv_o.luma_first >= Y_MIN &&
    yuv_o.luma_first <= Y_MAX && yuv_o.luma_second >= Y_MIN && yuv_o.luma_second <= Y_MAX))
  `R2Y_ASSERT(a_chroma_range, yuv_o.valid |-> (yuv_o.chroma_blue >= C_MIN &&
    yuv_o.chroma_blue <= C_MAX && yuv_o.chroma_red >= C_MIN && yuv_o.chroma_red <= C_MAX))
  `R2Y_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !yuv_o.valid)

endmodule
